FILE: rtl/core/dgt_pkg.sv
// Shared types, codes and defaults for the dependency graph table.
`default_nettype none
package dgt_pkg;

  localparam int DefMaxNodes = 16;
  localparam int IdW         = 32;
  localparam int ModeW       = 3;
  localparam int StatusW     = 2;

  typedef logic [ModeW-1:0] mode_t;
  localparam mode_t MODE_CLEAR      = 3'd0;
  localparam mode_t MODE_ADD_NODE   = 3'd1;
  localparam mode_t MODE_ADD_EDGE   = 3'd2;
  localparam mode_t MODE_QUERY_EDGE = 3'd3;
  localparam mode_t MODE_LIST       = 3'd4;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ROW,
    S_WALK,
    S_FETCH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear_all;
    logic inv_en;
    logic wr_en;
    logic rd_en;
  } adj_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/dgt_id_table.sv
// Node identifier memory with one write port and one registered read port.
`default_nettype none
module dgt_id_table
  import dgt_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  wire logic [IdW-1:0]               wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic      [IdW-1:0]               rd_data
);

  logic [IdW-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dgt_adj_rows.sv
// Adjacency row memory with per-row valid bits so that cleared rows read as zero.
`default_nettype none
module dgt_adj_rows
  import dgt_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire adj_ctl_t                     ctl,
  input  wire logic [$clog2(MAX_NODES)-1:0] inv_addr,
  input  wire logic [$clog2(MAX_NODES)-1:0] wr_addr,
  input  wire logic [MAX_NODES-1:0]         wr_data,
  input  wire logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic      [MAX_NODES-1:0]         rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid;
  logic [MAX_NODES-1:0] rd_q;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.inv_en) begin
        row_valid[inv_addr] <= 1'b0;
      end
      if (ctl.rd_en) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

FILE: rtl/core/dependency_graph_table.sv
// Dependency graph table: node identifier table, node count and adjacency matrix.
//
// One command word enters on the s_ channel; the mode in s_tuser selects clear,
// add node, add edge, query edge or list dependencies. Every command yields one
// result word on the m_ channel with m_tlast set, except a list of a node with
// dependencies, which yields one word per dependency in table order and sets
// m_tlast on the final one. The block takes one command at a time: s_tready is
// high only when the sequencer is idle.
// Sequence: clear and unused modes load their result straight into the response
// register when the command word is accepted. Every other command scans the
// identifier table through its single read port, one entry a cycle, before its
// result is loaded; add edge, query edge and list first read their adjacency
// row when the identifiers they name are found. A list then walks the row one
// bit a cycle and fetches the identifier of each dependency, waiting while the
// output register is full.
// Results leave through one output register; when the receiver stalls the
// sequencer holds its result until the register is free.
// Reset empties the graph at once: node count zero and all adjacency rows
// marked invalid, so they read as zero.
`default_nettype none
module dependency_graph_table
  import dgt_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,  // first_id[31:0], second_id[63:32]
  input  wire logic [2:0]  s_tuser,  // mode[2:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,  // edge_present[0], dep_id[32:1], zero[39:33]
  output logic      [2:0]  m_tuser,  // status[1:0], dep_valid[2]
  output logic             m_tlast
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic [MAX_NODES-1:0] ROW_ONE = 1;

  state_t               state, state_next;
  mode_t                mode_q;
  logic [IdW-1:0]       a_q, b_q;
  logic [CW-1:0]        count;
  logic [CW-1:0]        sidx;
  logic                 pend;
  logic [IW-1:0]        pidx;
  logic                 fa, fb;
  logic [IW-1:0]        ua, ub;
  logic [MAX_NODES-1:0] row_q;
  logic [IW-1:0]        widx;
  logic                 last_q;
  status_t              r_status;
  logic                 r_edge;

  logic                 issue, done, out_free;
  logic                 accept, cnt_inc, walk_ld, walk_take, widx_inc;
  logic                 resp_ld;
  status_t              resp_st;
  logic                 resp_ed;
  logic                 out_load;
  status_t              out_status;
  logic                 out_edge, out_dv, out_last;
  logic [IdW-1:0]       out_dep;
  logic                 id_wr, id_rd;
  logic [IW-1:0]        id_raddr;
  logic [IdW-1:0]       id_rdata;
  adj_ctl_t             adj_ctl;
  logic [IW-1:0]        adj_raddr;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [MAX_NODES-1:0] adj_rdata;
  logic [MAX_NODES-1:0] cmask;
  logic [MAX_NODES-1:0] masked;

  dgt_id_table #(.MAX_NODES(MAX_NODES)) u_ids (
    .clk     (clk),
    .wr_en   (id_wr),
    .wr_addr (count[IW-1:0]),
    .wr_data (a_q),
    .rd_en   (id_rd),
    .rd_addr (id_raddr),
    .rd_data (id_rdata)
  );

  dgt_adj_rows #(.MAX_NODES(MAX_NODES)) u_adj (
    .clk      (clk),
    .rst      (rst),
    .ctl      (adj_ctl),
    .inv_addr (count[IW-1:0]),
    .wr_addr  (ua),
    .wr_data  (adj_wdata),
    .rd_addr  (adj_raddr),
    .rd_data  (adj_rdata)
  );

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      cmask[i] = (CW'(i) < count);
    end
  end

  assign masked    = adj_rdata & cmask;
  assign adj_wdata = adj_rdata | (ROW_ONE << ub);
  assign adj_raddr = ua;
  assign issue     = (sidx < count);
  assign done      = !issue && !pend;
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    cnt_inc    = 1'b0;
    walk_ld    = 1'b0;
    walk_take  = 1'b0;
    widx_inc   = 1'b0;
    resp_ld    = 1'b0;
    resp_st    = ST_OK;
    resp_ed    = 1'b0;
    out_load   = 1'b0;
    out_status = ST_OK;
    out_edge   = 1'b0;
    out_dv     = 1'b0;
    out_dep    = '0;
    out_last   = 1'b1;
    id_wr      = 1'b0;
    id_rd      = 1'b0;
    id_raddr   = sidx[IW-1:0];
    adj_ctl    = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          accept = 1'b1;
          if (s_tuser inside {MODE_ADD_NODE, MODE_ADD_EDGE, MODE_QUERY_EDGE, MODE_LIST}) begin
            state_next = S_SEARCH;
          end else begin
            adj_ctl.clear_all = (s_tuser == MODE_CLEAR);
            resp_ld           = 1'b1;
            state_next        = S_RESP;
          end
        end
      end
      S_SEARCH: begin
        id_rd = issue;
        if (done) begin
          case (mode_q)
            MODE_ADD_NODE: begin
              resp_ld    = 1'b1;
              state_next = S_RESP;
              if (count == CW'(MAX_NODES)) begin
                resp_st = ST_FULL;
              end else if (fa) begin
                resp_st = ST_DUP;
              end else begin
                id_wr          = 1'b1;
                adj_ctl.inv_en = 1'b1;
                cnt_inc        = 1'b1;
              end
            end
            MODE_ADD_EDGE, MODE_QUERY_EDGE: begin
              if (fa && fb) begin
                adj_ctl.rd_en = 1'b1;
                state_next    = S_ROW;
              end else begin
                resp_ld    = 1'b1;
                resp_st    = ST_MISSING;
                state_next = S_RESP;
              end
            end
            MODE_LIST: begin
              if (fa) begin
                adj_ctl.rd_en = 1'b1;
                state_next    = S_ROW;
              end else begin
                resp_ld    = 1'b1;
                resp_st    = ST_MISSING;
                state_next = S_RESP;
              end
            end
            default: begin
              resp_ld    = 1'b1;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_ROW: begin
        case (mode_q)
          MODE_ADD_EDGE: begin
            adj_ctl.wr_en = 1'b1;
            resp_ld       = 1'b1;
            state_next    = S_RESP;
          end
          MODE_QUERY_EDGE: begin
            resp_ld    = 1'b1;
            resp_ed    = adj_rdata[ub];
            state_next = S_RESP;
          end
          MODE_LIST: begin
            if (masked == '0) begin
              resp_ld    = 1'b1;
              state_next = S_RESP;
            end else begin
              walk_ld    = 1'b1;
              state_next = S_WALK;
            end
          end
          default: begin
            resp_ld    = 1'b1;
            state_next = S_RESP;
          end
        endcase
      end
      S_WALK: begin
        id_raddr = widx;
        if (row_q[widx]) begin
          id_rd      = 1'b1;
          walk_take  = 1'b1;
          state_next = S_FETCH;
        end else begin
          widx_inc = 1'b1;
        end
      end
      S_FETCH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_dv   = 1'b1;
          out_dep  = id_rdata;
          out_last = last_q;
          if (last_q) begin
            state_next = S_IDLE;
          end else begin
            widx_inc   = 1'b1;
            state_next = S_WALK;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_status = r_status;
          out_edge   = r_edge;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && s_tuser == MODE_CLEAR) begin
      count <= '0;
    end else if (cnt_inc) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= s_tuser;
      a_q    <= s_tdata[31:0];
      b_q    <= s_tdata[63:32];
      sidx   <= '0;
      pend   <= 1'b0;
      fa     <= 1'b0;
      fb     <= 1'b0;
    end else if (state == S_SEARCH) begin
      pend <= issue;
      if (issue) begin
        sidx <= sidx + CW'(1);
        pidx <= sidx[IW-1:0];
      end
      if (pend) begin
        if (!fa && id_rdata == a_q) begin
          fa <= 1'b1;
          ua <= pidx;
        end
        if (!fb && id_rdata == b_q) begin
          fb <= 1'b1;
          ub <= pidx;
        end
      end
    end
    if (resp_ld) begin
      r_status <= resp_st;
      r_edge   <= resp_ed;
    end
    if (walk_ld) begin
      row_q <= masked;
      widx  <= '0;
    end else begin
      if (walk_take) begin
        row_q[widx] <= 1'b0;
        last_q      <= ((row_q & ~(ROW_ONE << widx)) == '0);
      end
      if (widx_inc) begin
        widx <= widx + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'b0, out_dep, out_edge};
      m_tuser <= {out_dv, out_status};
      m_tlast <= out_last;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_NODES))
    else $error("node count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while the previous one is still running");

  a_not_last_is_dep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser[2])
    else $error("non-final result word without a dependency");

  a_dep_word_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK && !m_tdata[0])
    else $error("dependency word with bad status or edge flag");

endmodule
`default_nettype wire
